### hw/rtl/sdt_pkg.sv
// Shared types and constants of the stereo dual-tap delay unit.
// No dependencies; every other file in this block imports it.

package sdt_pkg;

   // Configuration registers: width of each and the index of each on the write port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int DLY_W      = 15;
   localparam int GAIN_W     = 15;

   localparam logic [CSR_IDX_W-1:0] REG_LEFT_DELAY  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_DELAY = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_GAIN   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_GAIN  = 8'd3;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd32767;

   // Index arithmetic width: covers the largest supported frame count plus one
   localparam int IDX_CALC_W = 17;

   // Output queue: holds frames that have left the pipeline but are not yet delivered
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int CNT_W      = 3;

   // Delay reduction: reciprocal of the frame count and the product width
   localparam int RED_RECIP_W = DLY_W + 2;
   localparam int RED_PROD_W  = DLY_W + RED_RECIP_W;

   // Per-tap read qualifiers, carried next to the read of the frame store
   typedef struct packed {
      logic hit;     // tap reads the frame written in the same cycle
      logic filled;  // tap entry was written by an earlier frame
   } sdt_tap_flag_type;

endpackage

### hw/rtl/sdt_delay_mod.sv
// Delay reduction unit: takes a written delay modulo the frame count by a reciprocal
// multiply: quotient in the write cycle, remainder in the next cycle. Depends on sdt_pkg.

module sdt_delay_mod
   import sdt_pkg::*;
#(
   parameter int FRAMES = 32768
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DLY_W-1:0] value,
   output logic             busy,
   output logic             done,
   output logic [DLY_W-1:0] result
);

   // shift of DLY_W plus the ceiling log2 of the frame count keeps the quotient exact
   localparam int     RED_SHIFT  = DLY_W + $clog2(FRAMES);
   localparam longint RECIP_FULL = ((longint'(1) << RED_SHIFT) + longint'(FRAMES) - 1)
                                   / longint'(FRAMES);
   localparam logic [RED_RECIP_W-1:0] RECIP = RED_RECIP_W'(RECIP_FULL);

   logic                  busy_ff;
   logic [DLY_W-1:0]      val_ff;
   logic [DLY_W-1:0]      quot_ff, quot_in;
   logic [RED_PROD_W-1:0] prod_x;
   logic [RED_PROD_W-1:0] back_x;

   always_comb begin
      prod_x  = RED_PROD_W'(value) * RED_PROD_W'(RECIP);
      quot_in = DLY_W'(prod_x >> RED_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         quot_ff <= quot_in;
      end
   end

   // remainder fits DLY_W bits, so the low bits of the difference are exact
   always_comb begin
      back_x = RED_PROD_W'(quot_ff) * RED_PROD_W'(FRAMES);
      result = val_ff - back_x[DLY_W-1:0];
   end

   assign busy = busy_ff;
   assign done = busy_ff;

endmodule

### hw/rtl/sdt_tap.sv
// One channel of the frame store: sample memory, delayed read and gain multiply.
// Depends on sdt_pkg.

module sdt_tap
   import sdt_pkg::*;
#(
   parameter  int FRAMES      = 32768,
   parameter  int SAMPLE_BITS = 16,
   localparam int PTR_W       = $clog2(FRAMES)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [PTR_W-1:0]              wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic [PTR_W-1:0]              rd_addr,
   input  sdt_tap_flag_type              flag_in,
   input  logic [GAIN_W-1:0]             gain,
   output logic signed [SAMPLE_BITS-1:0] scaled_out
);

   localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

   logic signed [SAMPLE_BITS-1:0] frame_mem [FRAMES];

   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   sdt_tap_flag_type              flag_ff;
   logic signed [SAMPLE_BITS-1:0] tap_sample;
   logic signed [PROD_W-1:0]      prod_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      sample_ff <= wr_data;
      flag_ff   <= flag_in;
      prod_ff   <= PROD_W'(tap_sample) * PROD_W'($signed({1'b0, gain}));
   end

   // forward the frame written alongside the read; unwritten entries read as zero
   always_comb begin
      priority if (flag_ff.hit) begin
         tap_sample = sample_ff;
      end else if (flag_ff.filled) begin
         tap_sample = rd_data_ff;
      end else begin
         tap_sample = '0;
      end
   end

   // arithmetic shift by the gain fraction bits; the gain is below one so it fits
   assign scaled_out = prod_ff[SAMPLE_BITS+GAIN_W-1:GAIN_W];

endmodule

### hw/rtl/sdt_out_fifo.sv
// Small output queue that decouples the fixed pipeline from the result receiver.
// Depends on sdt_pkg.

module sdt_out_fifo
   import sdt_pkg::*;
#(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              out_valid,
   output logic [DATA_W-1:0] out_data
);

   logic [DATA_W-1:0]  entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

### hw/rtl/stereo_dual_tap_delay_unit.sv
// Stereo delay line with one delayed, scaled tap per channel.
// Depends on sdt_pkg, sdt_delay_mod, sdt_tap and sdt_out_fifo.
//
// Usage:
//   req_*  : one stereo frame per transfer, left sample in the low half of tdata.
//   rsp_*  : one scaled, delayed stereo frame per accepted frame, same packing.
//   csr_*  : register writes (left/right delay in frames, left/right Q0.15 gain).
// A frame passes the frame-store read, gain product and output queue registers
// before rsp_tvalid. Throughput is one frame per cycle while req_tready is high,
// set by the frame store: one write and one read port per channel each cycle,
// with the same-cycle frame forwarded for a delay of zero. A delay write is
// reduced modulo FRAMES by a reciprocal multiply: quotient in the write cycle,
// remainder in the cycle after; req_tready and csr_ready stay low meanwhile.
// Reset clears the write pointer and the fill tracking; store entries never
// written read as zero without a clearing pass, so the block is ready at once.
// When the receiver stalls, up to four frames are held in the output queue;
// req_tready drops once four frames are accepted but not yet delivered.

module stereo_dual_tap_delay_unit
   import sdt_pkg::*;
#(
   parameter  int FRAMES      = 32768,
   parameter  int SAMPLE_BITS = 16,
   localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,   // left_in, right_in, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_W-1:0]    rsp_tdata,   // left_out, right_out, zero pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PTR_W  = $clog2(FRAMES);
   localparam int PAIR_W = 2 * SAMPLE_BITS;

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic              wrapped_ff, wrapped_in;
   logic [DLY_W-1:0]  dly_l_ff, dly_l_in;
   logic [DLY_W-1:0]  dly_r_ff, dly_r_in;
   logic [GAIN_W-1:0] gain_l_ff, gain_l_in;
   logic [GAIN_W-1:0] gain_r_ff, gain_r_in;
   logic              tgt_right_ff, tgt_right_in;
   logic              v1_ff, v2_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic                          req_xfer, rsp_xfer, csr_xfer;
   logic                          red_start, red_busy, red_done;
   logic [DLY_W-1:0]              red_result;
   logic [IDX_CALC_W-1:0]         newest_x, dl_x, dr_x, idx_l_x, idx_r_x;
   logic [PTR_W-1:0]              idx_l, idx_r;
   sdt_tap_flag_type              flag_l, flag_r;
   logic signed [SAMPLE_BITS-1:0] left_in, right_in, left_out, right_out;
   logic [PAIR_W-1:0]             fifo_data;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign csr_xfer = csr_valid && csr_ready;

   assign req_tready = !red_busy && (cnt_ff < CNT_W'(FIFO_DEPTH));
   assign csr_ready  = !red_busy;

   assign left_in  = req_tdata[SAMPLE_BITS-1:0];
   assign right_in = req_tdata[PAIR_W-1:SAMPLE_BITS];

   // configuration decode
   always_comb begin
      gain_l_in    = gain_l_ff;
      gain_r_in    = gain_r_ff;
      tgt_right_in = tgt_right_ff;
      red_start    = 1'b0;
      if (csr_xfer) begin
         unique case (csr_index)
            REG_LEFT_DELAY: begin
               red_start    = 1'b1;
               tgt_right_in = 1'b0;
            end
            REG_RIGHT_DELAY: begin
               red_start    = 1'b1;
               tgt_right_in = 1'b1;
            end
            REG_LEFT_GAIN:  gain_l_in = csr_data[GAIN_W-1:0];
            REG_RIGHT_GAIN: gain_r_in = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      dly_l_in = dly_l_ff;
      dly_r_in = dly_r_ff;
      if (red_done) begin
         if (tgt_right_ff) begin
            dly_r_in = red_result;
         end else begin
            dly_l_in = red_result;
         end
      end
   end

   sdt_delay_mod #(
      .FRAMES (FRAMES)
   ) u_delay_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (red_start),
      .value  (csr_data[DLY_W-1:0]),
      .busy   (red_busy),
      .done   (red_done),
      .result (red_result)
   );

   // write pointer and fill tracking
   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (req_xfer) begin
         if (wp_ff == PTR_W'(FRAMES - 1)) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   // tap addresses: newest minus reduced delay, wrapped into the store
   always_comb begin
      newest_x = IDX_CALC_W'(wp_ff);
      dl_x     = IDX_CALC_W'(dly_l_ff);
      dr_x     = IDX_CALC_W'(dly_r_ff);
      idx_l_x  = (newest_x >= dl_x) ? newest_x - dl_x
                                    : newest_x + IDX_CALC_W'(FRAMES) - dl_x;
      idx_r_x  = (newest_x >= dr_x) ? newest_x - dr_x
                                    : newest_x + IDX_CALC_W'(FRAMES) - dr_x;
      idx_l    = idx_l_x[PTR_W-1:0];
      idx_r    = idx_r_x[PTR_W-1:0];
      flag_l.hit    = (dly_l_ff == '0);
      flag_l.filled = wrapped_ff || (idx_l < wp_ff);
      flag_r.hit    = (dly_r_ff == '0);
      flag_r.filled = wrapped_ff || (idx_r < wp_ff);
   end

   sdt_tap #(
      .FRAMES      (FRAMES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tap_left (
      .clock      (clock),
      .wr_en      (req_xfer),
      .wr_addr    (wp_ff),
      .wr_data    (left_in),
      .rd_addr    (idx_l),
      .flag_in    (flag_l),
      .gain       (gain_l_ff),
      .scaled_out (left_out)
   );

   sdt_tap #(
      .FRAMES      (FRAMES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tap_right (
      .clock      (clock),
      .wr_en      (req_xfer),
      .wr_addr    (wp_ff),
      .wr_data    (right_in),
      .rd_addr    (idx_r),
      .flag_in    (flag_r),
      .gain       (gain_r_ff),
      .scaled_out (right_out)
   );

   // frames accepted but not yet delivered; bounds the output queue
   assign cnt_in = cnt_ff + CNT_W'(req_xfer) - CNT_W'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         dly_l_ff   <= '0;
         dly_r_ff   <= '0;
         gain_l_ff  <= GAIN_RESET;
         gain_r_ff  <= GAIN_RESET;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         dly_l_ff   <= dly_l_in;
         dly_r_ff   <= dly_r_in;
         gain_l_ff  <= gain_l_in;
         gain_r_ff  <= gain_r_in;
         v1_ff      <= req_xfer;
         v2_ff      <= v1_ff;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_right_ff <= tgt_right_in;
   end

   assign fifo_data = {right_out, left_out};

   logic [PAIR_W-1:0] rsp_pair;

   sdt_out_fifo #(
      .DATA_W (PAIR_W)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (v2_ff),
      .push_data (fifo_data),
      .pop       (rsp_xfer),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_pair)
   );

   assign rsp_tdata = TDATA_W'(rsp_pair);

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("in-flight frame count exceeds output queue depth");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      red_busy |-> !req_xfer && !csr_xfer)
      else $error("transfer taken while delay reduction runs");

   a_rsp_has_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != '0)
      else $error("result offered with no frame in flight");

   a_delay_reduced: assert property (@(posedge clock) disable iff (reset)
      !red_busy |-> (IDX_CALC_W'(dly_l_ff) < IDX_CALC_W'(FRAMES))
                 && (IDX_CALC_W'(dly_r_ff) < IDX_CALC_W'(FRAMES)))
      else $error("tap delay not reduced below frame count");

   a_pipe_feeds_queue: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> ##1 v2_ff)
      else $error("accepted frame lost in the pipeline");

endmodule
